>>> rtl/core/euler_angles_to_quaternion_defines.svh
// Assertion macros shared by the core RTL
`ifndef EULER_ANGLES_TO_QUATERNION_DEFINES_SVH
`define EULER_ANGLES_TO_QUATERNION_DEFINES_SVH
// same-cycle consequence
`define EAQ_ASSERT_IMPLY(lbl, clk, rst_n, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
    else $error("check failed");
// next-cycle consequence
`define EAQ_ASSERT_NEXT(lbl, clk, rst_n, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
    else $error("check failed");
`endif

>>> rtl/core/eaq_pkg.sv
// Package: constants, types and tables for the Euler-to-quaternion core
`default_nettype none
package eaq_pkg;
  localparam int ANGLE_BITS  = 16;
  localparam int TRIG_STAGES = 16;
  localparam int NSTG        = (TRIG_STAGES < 24) ? TRIG_STAGES : 24;
  localparam int PH_W        = 32;
  localparam int XY_W        = 34;
  localparam logic signed [XY_W-1:0] CORDIC_START = 34'sd652032874;
  localparam logic [PH_W-1:0] TURN_QUARTER = 32'd1073741824;
  // total pipeline depth: fold, CORDIC stages, round, pairs, triples, sum, final
  localparam int LAT = NSTG + 6;

  typedef logic signed [15:0] q15_t;
  typedef logic signed [XY_W-1:0] xy_t;
  typedef logic signed [PH_W:0] res_t;

  typedef struct packed {
    xy_t  x;
    xy_t  y;
    res_t z;
    logic folded;
  } cord_t;

  function automatic res_t atan_phase(input int i);
    logic [31:0] v;
    case (i)
      0: v = 32'd536870912;  1: v = 32'd316933406; 2: v = 32'd167458907;
      3: v = 32'd85004756;   4: v = 32'd42667331;  5: v = 32'd21354465;
      6: v = 32'd10679838;   7: v = 32'd5340245;   8: v = 32'd2670163;
      9: v = 32'd1335087;    10: v = 32'd667544;   11: v = 32'd333772;
      12: v = 32'd166886;    13: v = 32'd83443;    14: v = 32'd41722;
      15: v = 32'd20861;     16: v = 32'd10430;    17: v = 32'd5215;
      18: v = 32'd2608;      19: v = 32'd1304;     20: v = 32'd652;
      21: v = 32'd326;       22: v = 32'd163;      default: v = 32'd81;
    endcase
    return res_t'({1'b0, v});
  endfunction

  function automatic q15_t rnd15(input xy_t v);
    xy_t t;
    t = (v + xy_t'(16384)) >>> 15;
    if (t > xy_t'(32767)) return 16'sh7fff;
    if (t < -xy_t'(32768)) return 16'sh8000;
    return q15_t'(t);
  endfunction
endpackage
`default_nettype wire

>>> rtl/core/eaq_sincos.sv
// Pipelined half-angle sine/cosine: fold, CORDIC stages, rounding
`default_nettype none
module eaq_sincos (
  input  wire logic                          clk,
  input  wire logic                          en,
  input  wire logic [eaq_pkg::ANGLE_BITS-1:0] angle,
  output eaq_pkg::q15_t                       sin_q,
  output eaq_pkg::q15_t                       cos_q
);
  localparam int N = eaq_pkg::NSTG;
  eaq_pkg::cord_t st_r [0:N];
  eaq_pkg::cord_t st_nxt [0:N];
  eaq_pkg::q15_t  sin_r, cos_r;
  logic [eaq_pkg::PH_W-1:0] half;

  always_comb begin
    half = {angle, {(eaq_pkg::PH_W - eaq_pkg::ANGLE_BITS){1'b0}}} >> 1;
    st_nxt[0].x = eaq_pkg::CORDIC_START;
    st_nxt[0].y = '0;
    st_nxt[0].folded = (half >= eaq_pkg::TURN_QUARTER);
    st_nxt[0].z = st_nxt[0].folded ? eaq_pkg::res_t'({1'b0, half - eaq_pkg::TURN_QUARTER})
                                   : eaq_pkg::res_t'({1'b0, half});
  end

  for (genvar i = 0; i < N; i++) begin : g_stage
    always_comb begin
      st_nxt[i+1].folded = st_r[i].folded;
      if (!st_r[i].z[eaq_pkg::PH_W]) begin
        st_nxt[i+1].x = st_r[i].x - (st_r[i].y >>> i);
        st_nxt[i+1].y = st_r[i].y + (st_r[i].x >>> i);
        st_nxt[i+1].z = st_r[i].z - eaq_pkg::atan_phase(i);
      end else begin
        st_nxt[i+1].x = st_r[i].x + (st_r[i].y >>> i);
        st_nxt[i+1].y = st_r[i].y - (st_r[i].x >>> i);
        st_nxt[i+1].z = st_r[i].z + eaq_pkg::atan_phase(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k <= N; k++) st_r[k] <= st_nxt[k];
      sin_r <= st_r[N].folded ? eaq_pkg::rnd15(st_r[N].x) : eaq_pkg::rnd15(st_r[N].y);
      cos_r <= st_r[N].folded ? eaq_pkg::rnd15(-st_r[N].y) : eaq_pkg::rnd15(st_r[N].x);
    end
  end
  assign sin_q = sin_r;
  assign cos_q = cos_r;
endmodule
`default_nettype wire

>>> rtl/core/eaq_combine.sv
// Three-way products and rounding into the four quaternion slots
`default_nettype none
module eaq_combine (
  input  wire logic          clk,
  input  wire logic          en,
  input  eaq_pkg::q15_t      sx, cx, sy, cy, sz, cz,
  output eaq_pkg::q15_t      q0, q1, q2, q3
);
  typedef logic signed [31:0] p2_t;
  typedef logic signed [47:0] p3_t;
  typedef logic signed [49:0] s_t;
  p2_t cxcy_r, sxsy_r, sxcy_r, cxsy_r;
  eaq_pkg::q15_t sz_r, cz_r;
  p3_t t_r [0:7];
  s_t  s_r [0:3];
  eaq_pkg::q15_t q_r [0:3];

  function automatic eaq_pkg::q15_t fin(input s_t v);
    s_t t;
    t = (v + s_t'(536870912)) >>> 30;
    if (t > s_t'(32767)) return 16'sh7fff;
    if (t < -s_t'(32768)) return 16'sh8000;
    return eaq_pkg::q15_t'(t);
  endfunction

  always_ff @(posedge clk) begin
    if (en) begin
      cxcy_r <= p2_t'(cx) * p2_t'(cy);
      sxsy_r <= p2_t'(sx) * p2_t'(sy);
      sxcy_r <= p2_t'(sx) * p2_t'(cy);
      cxsy_r <= p2_t'(cx) * p2_t'(sy);
      sz_r <= sz; cz_r <= cz;
      t_r[0] <= p3_t'(sz_r) * p3_t'(cxcy_r);
      t_r[1] <= p3_t'(cz_r) * p3_t'(sxsy_r);
      t_r[2] <= p3_t'(cz_r) * p3_t'(sxcy_r);
      t_r[3] <= p3_t'(sz_r) * p3_t'(cxsy_r);
      t_r[4] <= p3_t'(cz_r) * p3_t'(cxsy_r);
      t_r[5] <= p3_t'(sz_r) * p3_t'(sxcy_r);
      t_r[6] <= p3_t'(cz_r) * p3_t'(cxcy_r);
      t_r[7] <= p3_t'(sz_r) * p3_t'(sxsy_r);
      s_r[0] <= s_t'(t_r[0]) - s_t'(t_r[1]);
      s_r[1] <= s_t'(t_r[2]) + s_t'(t_r[3]);
      s_r[2] <= s_t'(t_r[4]) - s_t'(t_r[5]);
      s_r[3] <= s_t'(t_r[6]) + s_t'(t_r[7]);
      for (int k = 0; k < 4; k++) q_r[k] <= fin(s_r[k]);
    end
  end
  assign q0 = q_r[0];
  assign q1 = q_r[1];
  assign q2 = q_r[2];
  assign q3 = q_r[3];
endmodule
`default_nettype wire

>>> rtl/core/euler_angles_to_quaternion.sv
// Inputs pass the fold, CORDIC, round, pair, triple, sum and final registers to output valid.
// Throughput: one item per cycle; the whole pipeline advances when the output
// register is empty or its transfer completes, so a stall freezes every stage.
// Reset clears only the valid bits; data registers hold whatever they held.
// Stateless: each result depends only on its own three angles.
`default_nettype none
`include "euler_angles_to_quaternion_defines.svh"
module euler_angles_to_quaternion (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [15:0] in_angle_x,
  input  wire logic [15:0] in_angle_y,
  input  wire logic [15:0] in_angle_z,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic signed [15:0] out_slot_zero,
  output logic signed [15:0] out_slot_one,
  output logic signed [15:0] out_slot_two,
  output logic signed [15:0] out_slot_three
);
  localparam int L = eaq_pkg::LAT;
  logic [L-1:0] vld_r, vld_nxt;
  logic adv;
  eaq_pkg::q15_t sx, cx, sy, cy, sz, cz;

  assign adv = !vld_r[L-1] || !out_stall;
  assign in_stall = !adv;
  assign vld_nxt = {vld_r[L-2:0], in_valid};

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= '0;
    else if (adv) vld_r <= vld_nxt;
  end

  eaq_sincos u_x (.clk, .en(adv),
    .angle(in_angle_x[eaq_pkg::ANGLE_BITS-1:0]), .sin_q(sx), .cos_q(cx));
  eaq_sincos u_y (.clk, .en(adv),
    .angle(in_angle_y[eaq_pkg::ANGLE_BITS-1:0]), .sin_q(sy), .cos_q(cy));
  eaq_sincos u_z (.clk, .en(adv),
    .angle(in_angle_z[eaq_pkg::ANGLE_BITS-1:0]), .sin_q(sz), .cos_q(cz));

  eaq_combine u_comb (.clk, .en(adv), .sx, .cx, .sy, .cy, .sz, .cz,
    .q0(out_slot_zero), .q1(out_slot_one), .q2(out_slot_two), .q3(out_slot_three));

  assign out_valid = vld_r[L-1];

  `EAQ_ASSERT_NEXT(a_hold_valid, clk, rst_n, out_valid && out_stall, out_valid)
  `EAQ_ASSERT_IMPLY(a_stall_link, clk, rst_n, in_stall, out_valid && out_stall)
  `EAQ_ASSERT_NEXT(a_enter, clk, rst_n, in_valid && !in_stall, vld_r[0])
endmodule
`default_nettype wire

>>> dv/tb.sv
// Testbench for euler_angles_to_quaternion: directed table plus random stream, scoreboard check
`timescale 1ns / 100ps
`default_nettype none
module tb;
  localparam int N_RANDOM = 1730;
  localparam int DRAIN_CYCLES = eaq_pkg::LAT + 10;

  typedef struct {
    logic [15:0] ax, ay, az;
    logic        known;  // set when q0..q3 hold an expected value typed in below
    logic signed [15:0] q0, q1, q2, q3;
  } row_t;

  typedef struct {
    logic signed [15:0] q0, q1, q2, q3;
  } quat_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [15:0] in_angle_x = '0, in_angle_y = '0, in_angle_z = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [15:0] out_slot_zero, out_slot_one, out_slot_two, out_slot_three;

  quat_t quat_queue[$];
  int errors = 0;
  int n_sent = 0;
  int n_got = 0;
  bit calm = 1'b0;  // no idling while set

  always #5 clk = ~clk;

  euler_angles_to_quaternion dut (.*);

  function automatic longint sat16(input longint v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  // sine and cosine of half the angle, Q1.15
  function automatic void half_trig(input logic [15:0] ang, output longint s, output longint c);
    longint x, y, z, nx, ny, half, t;
    longint atab[24] = '{536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
                         10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886,
                         83443, 41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81};
    bit folded;
    int n;
    half = longint'({ang, 16'h0000}) >> 1;
    folded = 0;
    if (half >= 64'd1073741824) begin
      half -= 1073741824;
      folded = 1;
    end
    x = 652032874;
    y = 0;
    z = half;
    n = (eaq_pkg::TRIG_STAGES < 24) ? eaq_pkg::TRIG_STAGES : 24;
    for (int i = 0; i < n; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i);
        ny = y + (x >>> i);
        z -= atab[i];
      end else begin
        nx = x + (y >>> i);
        ny = y - (x >>> i);
        z += atab[i];
      end
      x = nx;
      y = ny;
    end
    if (folded) begin
      t = x;
      y = -y;
      x = y;
      y = t;
    end
    s = sat16((y + 16384) >>> 15);
    c = sat16((x + 16384) >>> 15);
  endfunction

  function automatic quat_t euler_to_quat(input logic [15:0] ax, ay, az);
    longint sx, cx, sy, cy, sz, cz;
    quat_t q;
    half_trig(ax, sx, cx);
    half_trig(ay, sy, cy);
    half_trig(az, sz, cz);
    q.q0 = 16'(sat16((sz*cx*cy - cz*sx*sy + 536870912) >>> 30));
    q.q1 = 16'(sat16((cz*sx*cy + sz*cx*sy + 536870912) >>> 30));
    q.q2 = 16'(sat16((cz*cx*sy - sz*sx*cy + 536870912) >>> 30));
    q.q3 = 16'(sat16((cz*cx*cy + sz*sx*sy + 536870912) >>> 30));
    return q;
  endfunction

  // drive one transfer; hold until accepted
  task automatic send(input logic [15:0] ax, ay, az);
    while (!calm && $urandom_range(99) < 33) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_angle_x <= ax;
    in_angle_y <= ay;
    in_angle_z <= az;
    quat_queue.push_back(euler_to_quat(ax, ay, az));
    n_sent++;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic check_field(input string name, input logic signed [15:0] exp_v, act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_v, act_v);
      errors++;
    end
  endtask

  // result side: random stall, check each transfer
  always @(posedge clk) begin
    quat_t e;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        n_got++;
        if (quat_queue.size() == 0) begin
          $display("%0t: unexpected result transfer, got %0d %0d %0d %0d", $time,
                   out_slot_zero, out_slot_one, out_slot_two, out_slot_three);
          errors++;
        end else begin
          e = quat_queue.pop_front();
          check_field("slot_zero", e.q0, out_slot_zero);
          check_field("slot_one", e.q1, out_slot_one);
          check_field("slot_two", e.q2, out_slot_two);
          check_field("slot_three", e.q3, out_slot_three);
        end
      end
      out_stall <= !calm && ($urandom_range(99) < 33);
    end
  end

  initial begin
    row_t rows[$];
    row_t r;
    quat_t e;
    rows = '{
      // zero rotation: identity
      '{16'h0000, 16'h0000, 16'h0000, 1'b0, 16'sd0, 16'sd0, 16'sd0, 16'sd0},
      // half turn about each axis
      '{16'h8000, 16'h0000, 16'h0000, 1'b0, 16'sd0, 16'sd0, 16'sd0, 16'sd0},
      '{16'h0000, 16'h8000, 16'h0000, 1'b0, 16'sd0, 16'sd0, 16'sd0, 16'sd0},
      '{16'h0000, 16'h0000, 16'h8000, 1'b0, 16'sd0, 16'sd0, 16'sd0, 16'sd0},
      '{16'hffff, 16'hffff, 16'hffff, 1'b0, 16'sd0, 16'sd0, 16'sd0, 16'sd0},
      '{16'hffff, 16'h0000, 16'h0000, 1'b0, 16'sd0, 16'sd0, 16'sd0, 16'sd0},
      '{16'h0000, 16'hffff, 16'h0000, 1'b0, 16'sd0, 16'sd0, 16'sd0, 16'sd0},
      '{16'h0000, 16'h0000, 16'hffff, 1'b0, 16'sd0, 16'sd0, 16'sd0, 16'sd0},
      '{16'h4000, 16'h4000, 16'h4000, 1'b0, 16'sd0, 16'sd0, 16'sd0, 16'sd0},
      '{16'hc000, 16'hc000, 16'hc000, 1'b0, 16'sd0, 16'sd0, 16'sd0, 16'sd0},
      '{16'h7fff, 16'h8001, 16'h0001, 1'b0, 16'sd0, 16'sd0, 16'sd0, 16'sd0},
      '{16'h8000, 16'h8000, 16'h8000, 1'b0, 16'sd0, 16'sd0, 16'sd0, 16'sd0},
      '{16'h5555, 16'haaaa, 16'h1234, 1'b0, 16'sd0, 16'sd0, 16'sd0, 16'sd0},
      '{16'h2000, 16'h6000, 16'ha000, 1'b0, 16'sd0, 16'sd0, 16'sd0, 16'sd0},
      '{16'h0001, 16'h0001, 16'h0001, 1'b0, 16'sd0, 16'sd0, 16'sd0, 16'sd0}
    };
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (rows[i]) begin
      r = rows[i];
      send(r.ax, r.ay, r.az);
      if (r.known) begin
        // replace prediction with the typed-in value
        e = '{r.q0, r.q1, r.q2, r.q3};
        quat_queue[quat_queue.size() - 1] = e;
      end
    end
    // hold off until the pipeline has drained
    in_valid <= 1'b0;
    while (quat_queue.size() != 0) @(posedge clk);
    for (int k = 0; k < N_RANDOM; k++) begin
      calm = (k >= 600 && k < 900);
      case ($urandom_range(3))
        0: send(16'($urandom_range(3) << 14), 16'($urandom_range(3) << 14),
                16'($urandom_range(3) << 14));
        default: send(16'($urandom), 16'($urandom), 16'($urandom));
      endcase
    end
    calm = 1'b0;
    in_valid <= 1'b0;
    while (quat_queue.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Sent %0d angle triples (%0d directed), checked %0d quaternions,", n_sent,
             rows.size(), n_got);
    $display("with random idling on both sides and one stall-free stretch.");
    if (errors == 0) $display("tb OK");
    else $display("tb NOT OK");
    $finish;
  end

  initial begin
    #2_000_000;
    $display("timeout");
    $display("tb NOT OK");
    $finish;
  end
endmodule
`default_nettype wire
